FILE: rtl/core/a2rim_pkg.sv
`timescale 1ns / 1ps
package a2rim_pkg;

    // dividend width of the remainder pipelines
    localparam int unsigned DvdW = 32;

    localparam int unsigned LaneW = 24;
    localparam int unsigned SegW  = 30;
    localparam int unsigned ColW  = 32;

    // configuration register indexes
    localparam logic [7:0] CfgLaneCount = 8'd0;
    localparam logic [7:0] CfgSegLength = 8'd1;

    // side data that rides along the remainder pipelines
    typedef struct packed {
        logic [31:0]      j1;
        logic             pass_zero;
        logic [LaneW-1:0] cur_lane;
        logic [1:0]       slice;
    } t_item;

    typedef struct packed {
        logic [LaneW-1:0] ref_lane;
        logic [ColW-1:0]  ref_column;
        logic             invalid;
    } t_result;

    // one restoring remainder step: shift in one dividend bit, subtract if it fits
    function automatic logic [DvdW-1:0] rem_step(
        input logic [DvdW-1:0] rem,
        input logic            dbit,
        input logic [DvdW-1:0] div
    );
        logic [DvdW-1:0] t;
        begin
            t = {rem[DvdW-2:0], dbit};
            rem_step = (t >= div) ? (t - div) : t;
        end
    endfunction

endpackage

FILE: rtl/core/a2rim_rem_pipe.sv
`timescale 1ns / 1ps
// Two lock-step pipelined remainder units, one dividend bit per stage.
module a2rim_rem_pipe (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  a2rim_pkg::t_item              i_item,
    input  logic [a2rim_pkg::DvdW-1:0]    i_dvd_a,
    input  logic [a2rim_pkg::DvdW-1:0]    i_dvd_b,
    input  logic [a2rim_pkg::DvdW-1:0]    i_div_a,
    input  logic [a2rim_pkg::DvdW-1:0]    i_div_b,
    output logic                          o_valid,
    output a2rim_pkg::t_item              o_item,
    output logic [a2rim_pkg::DvdW-1:0]    o_rem_a,
    output logic [a2rim_pkg::DvdW-1:0]    o_rem_b
);
    localparam int unsigned N = a2rim_pkg::DvdW;

    logic [N-1:0]     w_rem_a [0:N];
    logic [N-1:0]     w_rem_b [0:N];
    logic [N-1:0]     w_dvd_a [0:N];
    logic [N-1:0]     w_dvd_b [0:N];
    a2rim_pkg::t_item w_item  [0:N];
    logic             w_valid [0:N];

    assign w_rem_a[0] = '0;
    assign w_rem_b[0] = '0;
    assign w_dvd_a[0] = i_dvd_a;
    assign w_dvd_b[0] = i_dvd_b;
    assign w_item[0]  = i_item;
    assign w_valid[0] = i_valid;

    genvar k;
    generate
        for (k = 0; k < N; k++) begin : g_stage
            logic [N-1:0]     r_rem_a;
            logic [N-1:0]     r_rem_b;
            logic [N-1:0]     r_dvd_a;
            logic [N-1:0]     r_dvd_b;
            a2rim_pkg::t_item r_item;
            logic             r_valid;

            // stage k consumes dividend bit N-1-k
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem_a <= a2rim_pkg::rem_step(w_rem_a[k], w_dvd_a[k][N-1-k], i_div_a);
                    r_rem_b <= a2rim_pkg::rem_step(w_rem_b[k], w_dvd_b[k][N-1-k], i_div_b);
                    r_dvd_a <= w_dvd_a[k];
                    r_dvd_b <= w_dvd_b[k];
                    r_item  <= w_item[k];
                end
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_valid <= 1'b0;
                end else if (i_en) begin
                    r_valid <= w_valid[k];
                end
            end

            assign w_rem_a[k+1] = r_rem_a;
            assign w_rem_b[k+1] = r_rem_b;
            assign w_dvd_a[k+1] = r_dvd_a;
            assign w_dvd_b[k+1] = r_dvd_b;
            assign w_item[k+1]  = r_item;
            assign w_valid[k+1] = r_valid;
        end
    endgenerate

    assign o_valid = w_valid[N];
    assign o_item  = w_item[N];
    assign o_rem_a = w_rem_a[N];
    assign o_rem_b = w_rem_b[N];

endmodule

FILE: rtl/core/a2rim_ref_calc.sv
`timescale 1ns / 1ps
// Reference set size, position mapping and final column wrap.
module a2rim_ref_calc (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic                              i_valid,
    input  a2rim_pkg::t_item                  i_item,
    input  logic [a2rim_pkg::DvdW-1:0]        i_lane_rem,
    input  logic [a2rim_pkg::DvdW-1:0]        i_col_rem,
    input  logic [a2rim_pkg::SegW-1:0]        i_seg,
    input  logic [31:0]                       i_lane_len,
    output logic                              o_valid,
    output a2rim_pkg::t_result                o_res
);
    // stage 1: lane select, x = J1^2 >> 32, base and start
    logic                        r1_valid;
    logic [a2rim_pkg::LaneW-1:0] r1_lane;
    logic                        r1_same;
    logic [a2rim_pkg::SegW-1:0]  r1_pos;
    logic [31:0]                 r1_x;
    logic [31:0]                 r1_base;
    logic [31:0]                 r1_start;

    logic [a2rim_pkg::LaneW-1:0] s1_lane;
    logic [63:0]                 s1_sq;
    logic [31:0]                 s1_seg;
    logic [31:0]                 s1_base;
    logic [31:0]                 s1_start;

    always_comb begin
        s1_seg  = {2'b00, i_seg};
        s1_lane = (i_item.pass_zero && (i_item.slice == 2'd0)) ?
                  i_item.cur_lane : i_lane_rem[a2rim_pkg::LaneW-1:0];
        s1_sq   = {32'd0, i_item.j1} * {32'd0, i_item.j1};
        case (i_item.slice)
            2'd0:    begin s1_base = 32'd0;                  s1_start = s1_seg; end
            2'd1:    begin s1_base = s1_seg;                 s1_start = s1_seg << 1; end
            2'd2:    begin s1_base = s1_seg << 1;            s1_start = s1_seg + (s1_seg << 1); end
            default: begin s1_base = s1_seg + (s1_seg << 1); s1_start = s1_seg << 2; end
        endcase
        if (!i_item.pass_zero) begin
            s1_base = s1_seg + (s1_seg << 1);
        end else begin
            s1_start = 32'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_lane  <= s1_lane;
            r1_same  <= (s1_lane == i_item.cur_lane);
            r1_pos   <= i_col_rem[a2rim_pkg::SegW-1:0];
            r1_x     <= s1_sq[63:32];
            r1_base  <= s1_base;
            r1_start <= s1_start;
        end
    end

    // stage 2: signed set size and its validity
    logic                        r2_valid;
    logic [a2rim_pkg::LaneW-1:0] r2_lane;
    logic [31:0]                 r2_x;
    logic [31:0]                 r2_r;
    logic                        r2_ok;
    logic [31:0]                 r2_start;
    logic signed [33:0]          s2_size;

    always_comb begin
        if (r1_same) begin
            s2_size = $signed({2'b00, r1_base}) + $signed({4'd0, r1_pos}) - 34'sd1;
        end else begin
            s2_size = $signed({2'b00, r1_base}) - ((r1_pos == '0) ? 34'sd1 : 34'sd0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_lane  <= r1_lane;
            r2_x     <= r1_x;
            r2_r     <= s2_size[31:0];
            r2_ok    <= !s2_size[33] && (s2_size != 34'sd0);
            r2_start <= r1_start;
        end
    end

    // stage 3: y = R*x >> 32
    logic                        r3_valid;
    logic [a2rim_pkg::LaneW-1:0] r3_lane;
    logic [31:0]                 r3_r;
    logic [31:0]                 r3_y;
    logic                        r3_ok;
    logic [31:0]                 r3_start;
    logic [63:0]                 s3_prod;

    assign s3_prod = {32'd0, r2_r} * {32'd0, r2_x};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_lane  <= r2_lane;
            r3_r     <= r2_r;
            r3_y     <= s3_prod[63:32];
            r3_ok    <= r2_ok;
            r3_start <= r2_start;
        end
    end

    // stage 4: start + R - 1 - y
    logic                        r4_valid;
    logic [a2rim_pkg::LaneW-1:0] r4_lane;
    logic [33:0]                 r4_sum;
    logic                        r4_ok;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_lane <= r3_lane;
            r4_sum  <= {2'b00, r3_start} + {2'b00, r3_r} - 34'd1 - {2'b00, r3_y};
            r4_ok   <= r3_ok;
        end
    end

    // valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
            r4_valid <= r3_valid;
        end
    end

    // final wrap: sum stays below twice the lane length
    logic [33:0] s5_col;

    assign s5_col = (r4_sum >= {2'b00, i_lane_len}) ? (r4_sum - {2'b00, i_lane_len}) : r4_sum;

    assign o_valid          = r4_valid;
    assign o_res.ref_lane   = r4_lane;
    assign o_res.ref_column = r4_ok ? s5_col[31:0] : 32'd0;
    assign o_res.invalid    = !r4_ok;

endmodule

FILE: rtl/core/a2rim_out_skid.sv
`timescale 1ns / 1ps
// Output register plus one skid entry; the pipeline runs while the skid is empty.
module a2rim_out_skid (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  a2rim_pkg::t_result    i_res,
    input  logic                  i_ready,
    output logic                  o_en,
    output logic                  o_valid,
    output a2rim_pkg::t_result    o_res
);
    logic               r_out_valid;
    logic               r_skid_valid;
    a2rim_pkg::t_result r_out;
    a2rim_pkg::t_result r_skid;
    logic               w_take;

    assign o_en    = !r_skid_valid;
    assign w_take  = i_valid && !r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_res   = r_out;

    // valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (i_ready) begin
                r_skid_valid <= 1'b0;
            end
        end else if (w_take) begin
            if (!r_out_valid || i_ready) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (i_ready) begin
                r_out <= r_skid;
            end
        end else if (w_take) begin
            if (!r_out_valid || i_ready) begin
                r_out <= i_res;
            end else begin
                r_skid <= i_res;
            end
        end
    end

`ifndef SYNTHESIS
    a_skid_implies_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held without output entry");

    a_fill_skid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_take && r_out_valid && !i_ready) |=> r_skid_valid)
        else $error("item dropped while output stalled");

    a_drain_skid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && i_ready) |=> (r_out_valid && !r_skid_valid))
        else $error("skid entry not moved to output");
`endif

endmodule

FILE: rtl/core/argon2_reference_index_map_top.sv
`timescale 1ns / 1ps
// Argon2 reference block index map. Takes one item per cycle while the skid entry is empty and
// returns one result per item, in order, through 32 stages of two pipelined remainder units
// (J2 mod lane count, column mod segment length, one dividend bit per stage), four stages for
// set size, the two multiplies and the column sum, and the output register. The final wrap mod
// the lane length (four segments) is a single compare and subtract. A one-entry skid behind the
// output register lets the pipeline stop cleanly on backpressure. A lane count or segment
// length of zero acts as one. Write the configuration only while idle.
module argon2_reference_index_map_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    // configuration write channel
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [7:0]    i_cfg_index,
    input  logic [31:0]   i_cfg_data,
    // input items
    input  logic          i_s_axis_tvalid,
    output logic          o_s_axis_tready,
    // [63:0] j_value, [95:64] pass_index, [119:96] current_lane, [121:120] slice_index,
    // [153:122] column_index, [159:154] zero
    input  logic [159:0]  i_s_axis_tdata,
    // result items
    output logic          o_m_axis_tvalid,
    input  logic          i_m_axis_tready,
    // [23:0] ref_lane, [55:24] ref_column
    output logic [55:0]   o_m_axis_tdata,
    // [0] invalid
    output logic          o_m_axis_tuser
);
    logic [a2rim_pkg::LaneW-1:0] r_lanes;
    logic [a2rim_pkg::SegW-1:0]  r_seg;

    assign o_cfg_ready = 1'b1;

    // configuration registers, zero stored as one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lanes <= a2rim_pkg::LaneW'(1);
            r_seg   <= a2rim_pkg::SegW'(2);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                a2rim_pkg::CfgLaneCount: begin
                    r_lanes <= (i_cfg_data[23:0] == '0) ? a2rim_pkg::LaneW'(1) : i_cfg_data[23:0];
                end
                a2rim_pkg::CfgSegLength: begin
                    r_seg <= (i_cfg_data[29:0] == '0) ? a2rim_pkg::SegW'(1) : i_cfg_data[29:0];
                end
                default: ;
            endcase
        end
    end

    logic               w_en;
    a2rim_pkg::t_item   w_in_item;
    logic               w_rem_valid;
    a2rim_pkg::t_item   w_rem_item;
    logic [31:0]        w_lane_rem;
    logic [31:0]        w_col_rem;
    logic               w_calc_valid;
    a2rim_pkg::t_result w_calc_res;
    a2rim_pkg::t_result w_out_res;

    assign o_s_axis_tready     = w_en;
    assign w_in_item.j1        = i_s_axis_tdata[31:0];
    assign w_in_item.pass_zero = (i_s_axis_tdata[95:64] == 32'd0);
    assign w_in_item.cur_lane  = i_s_axis_tdata[119:96];
    assign w_in_item.slice     = i_s_axis_tdata[121:120];

    a2rim_rem_pipe u_rem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_s_axis_tvalid),
        .i_item  (w_in_item),
        .i_dvd_a (i_s_axis_tdata[63:32]),
        .i_dvd_b (i_s_axis_tdata[153:122]),
        .i_div_a ({8'd0, r_lanes}),
        .i_div_b ({2'b00, r_seg}),
        .o_valid (w_rem_valid),
        .o_item  (w_rem_item),
        .o_rem_a (w_lane_rem),
        .o_rem_b (w_col_rem)
    );

    a2rim_ref_calc u_calc (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_en),
        .i_valid    (w_rem_valid),
        .i_item     (w_rem_item),
        .i_lane_rem (w_lane_rem),
        .i_col_rem  (w_col_rem),
        .i_seg      (r_seg),
        .i_lane_len ({r_seg, 2'b00}),
        .o_valid    (w_calc_valid),
        .o_res      (w_calc_res)
    );

    a2rim_out_skid u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_calc_valid),
        .i_res   (w_calc_res),
        .i_ready (i_m_axis_tready),
        .o_en    (w_en),
        .o_valid (o_m_axis_tvalid),
        .o_res   (w_out_res)
    );

    assign o_m_axis_tdata = {w_out_res.ref_column, w_out_res.ref_lane};
    assign o_m_axis_tuser = w_out_res.invalid;

endmodule
